>>> sv/kcot_pkg.sv
// Package: table sizing, request/result types and status codes for the counter table.
`timescale 1ns / 1ps
`default_nettype none
package kcot_pkg;

  // Table sizing
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned KeyW = 64;
  localparam int unsigned CountW = 64;
  localparam int unsigned EntryW = KeyW + CountW;

  // Request kinds
  typedef enum logic {
    REQ_ACCUM = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DRAINED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Controller states
  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_SCAN = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [63:0]        key;
    logic signed [63:0] delta;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [63:0]        out_key;
    logic signed [63:0] out_count;
    logic               last;
  } rsp_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [KeyW-1:0]          key;
    logic signed [CountW-1:0] count;
  } entry_t;

  // Result emitted by the controller, before the output register
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } emit_t;

  // Memory access from the controller
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
  } mem_req_t;

endpackage
`default_nettype wire

>>> sv/keyed_counter_overflow_table.sv
// Top level of the keyed counter table: memory, controller and result register.
// The scan reads the filled entries in order, one entry per cycle: a match ends it at that
// entry, while an insert or drop and a drain's last result follow the full scan (with an
// empty table no entry is read). Results pass through the output register.
// A new request is taken only while busy is low, after the previous one has finished;
// results cannot be held off. Reset empties the table at once.
`timescale 1ns / 1ps
`default_nettype none
module keyed_counter_overflow_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire kcot_pkg::req_t   req_i,
  output logic                  rsp_valid_o,
  output kcot_pkg::rsp_t        rsp_o
);
  import kcot_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;
  emit_t    emit;
  logic     rsp_valid_q;
  rsp_t     rsp_q;

  kcot_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

  kcot_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .mem_o  (mem_req),
    .rdata_i(rdata),
    .emit_o (emit)
  );

  // Result strobe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= emit.valid;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      rsp_q <= emit.rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

>>> sv/kcot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kcot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; read data appears in the cycle after re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/kcot_ctrl.sv
// Controller: scans table entries in memory, merges, inserts, drops and drains.
`timescale 1ns / 1ps
`default_nettype none
module kcot_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire kcot_pkg::req_t    req_i,
  output kcot_pkg::mem_req_t     mem_o,
  input  wire kcot_pkg::entry_t  rdata_i,
  output kcot_pkg::emit_t        emit_o
);
  import kcot_pkg::*;

  ctrl_state_e state_q, state_d;
  req_t        req_q, req_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic            vld_q, vld_d;
  logic            pend_vld_q, pend_vld_d;
  entry_t          pend_q, pend_d;

  logic               issue;
  logic               hit;
  logic               keep;
  logic signed [63:0] sum;

  assign busy  = (state_q != CTRL_IDLE);
  assign issue = (rd_idx_q < fill_q);
  assign hit   = (rdata_i.key == req_q.key);
  assign keep  = (rdata_i.key != '0) && (rdata_i.count != '0);
  assign sum   = rdata_i.count + req_q.delta;

  // Next state, memory access and result selection
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    chk_idx_d  = chk_idx_q;
    vld_d      = 1'b0;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    mem_o      = '0;
    emit_o     = '0;

    case (state_q)
      CTRL_IDLE: begin
        if (start) begin
          req_d      = req_i;
          rd_idx_d   = '0;
          pend_vld_d = 1'b0;
          state_d    = CTRL_SCAN;
        end
      end

      CTRL_SCAN: begin
        // keep one read in flight per cycle
        if (issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = rd_idx_q[IdxW-1:0];
          chk_idx_d   = rd_idx_q[IdxW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          vld_d       = 1'b1;
        end

        if (vld_q) begin
          if (req_q.req_type == REQ_ACCUM) begin
            // match: write back the new count and finish
            if (hit) begin
              mem_o.we            = 1'b1;
              mem_o.waddr         = chk_idx_q;
              mem_o.wdata.key     = rdata_i.key;
              mem_o.wdata.count   = sum;
              emit_o.valid         = 1'b1;
              emit_o.rsp.status    = ST_MERGED;
              emit_o.rsp.out_key   = req_q.key;
              emit_o.rsp.out_count = sum;
              emit_o.rsp.last      = 1'b1;
              vld_d                = 1'b0;
              state_d              = CTRL_IDLE;
            end
          end else if (keep) begin
            // hold one entry back so the final one can be marked last
            if (pend_vld_q) begin
              emit_o.valid         = 1'b1;
              emit_o.rsp.status    = ST_DRAINED;
              emit_o.rsp.out_key   = pend_q.key;
              emit_o.rsp.out_count = pend_q.count;
              emit_o.rsp.last      = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_d     = rdata_i;
          end
        end else if (!issue) begin
          // scan exhausted
          state_d = CTRL_IDLE;
          if (req_q.req_type == REQ_ACCUM) begin
            emit_o.valid       = 1'b1;
            emit_o.rsp.out_key = req_q.key;
            emit_o.rsp.last    = 1'b1;
            if (fill_q < CntW'(TableEntries)) begin
              mem_o.we             = 1'b1;
              mem_o.waddr          = fill_q[IdxW-1:0];
              mem_o.wdata.key      = req_q.key;
              mem_o.wdata.count    = req_q.delta;
              fill_d               = fill_q + 1'b1;
              emit_o.rsp.status    = ST_INSERTED;
              emit_o.rsp.out_count = req_q.delta;
            end else begin
              emit_o.rsp.status    = ST_DROPPED;
              emit_o.rsp.out_count = '0;
            end
          end else begin
            emit_o.valid    = 1'b1;
            emit_o.rsp.last = 1'b1;
            fill_d          = '0;
            pend_vld_d      = 1'b0;
            if (pend_vld_q) begin
              emit_o.rsp.status    = ST_DRAINED;
              emit_o.rsp.out_key   = pend_q.key;
              emit_o.rsp.out_count = pend_q.count;
            end else begin
              emit_o.rsp.status    = ST_EMPTY;
              emit_o.rsp.out_key   = req_q.key;
              emit_o.rsp.out_count = '0;
            end
          end
        end
      end

      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CTRL_IDLE;
      fill_q     <= '0;
      rd_idx_q   <= '0;
      vld_q      <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      rd_idx_q   <= rd_idx_d;
      vld_q      <= vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    chk_idx_q <= chk_idx_d;
    pend_q    <= pend_d;
  end

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for the keyed counter table: directed corner cases, then random traffic.
`timescale 1ns / 1ps
module tb;
  import kcot_pkg::*;

  localparam int MaxReports = 10;
  localparam int RandItems = 345;
  localparam int FlatTail = 60;
  localparam int KeyPool = 20;

  // Mirror of the counter table; predicts the results of every accepted request
  class count_table_board;
    logic [63:0] keys[TableEntries];
    logic [63:0] counts[TableEntries];
    int unsigned fill;
    rsp_t expected_rsp[$];
    int errors;
    int requests;
    int drains;
    int seen[5];

    function new();
      fill = 0;
      errors = 0;
      requests = 0;
      drains = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    // Current count held under a key, zero if absent
    function logic [63:0] count_of(logic [63:0] k);
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == k) return counts[i];
      end
      return '0;
    endfunction

    function void push_rsp(status_e st, logic [63:0] k, logic [63:0] c, logic l);
      rsp_t r;
      r.status = st;
      r.out_key = k;
      r.out_count = c;
      r.last = l;
      expected_rsp.push_back(r);
    endfunction

    // Accepted request: update the table and queue what it must produce
    function void take_request(req_t r);
      int hit;
      int n;
      int emitted;
      hit = -1;
      requests++;
      if (r.req_type == REQ_ACCUM) begin
        for (int i = 0; i < fill; i++) begin
          if (hit < 0 && keys[i] == r.key) hit = i;
        end
        if (hit >= 0) begin
          counts[hit] = counts[hit] + r.delta;
          push_rsp(ST_MERGED, r.key, counts[hit], 1'b1);
        end else if (fill < TableEntries) begin
          keys[fill] = r.key;
          counts[fill] = r.delta;
          fill++;
          push_rsp(ST_INSERTED, r.key, r.delta, 1'b1);
        end else begin
          push_rsp(ST_DROPPED, r.key, '0, 1'b1);
        end
      end else begin
        drains++;
        n = 0;
        emitted = 0;
        for (int i = 0; i < fill; i++) begin
          if (keys[i] != '0 && counts[i] != '0) n++;
        end
        // entries with a zero key or zero count are cleared silently
        for (int i = 0; i < fill; i++) begin
          if (keys[i] != '0 && counts[i] != '0) begin
            emitted++;
            push_rsp(ST_DRAINED, keys[i], counts[i], emitted == n);
          end
        end
        if (n == 0) push_rsp(ST_EMPTY, r.key, '0, 1'b1);
        fill = 0;
      end
    endfunction

    // Result off the ports: compare with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        if (errors < MaxReports)
          $display("ERROR: unexpected result status %0d key %h count %0d last %b",
                   got.status, got.out_key, got.out_count, got.last);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status <= ST_EMPTY) seen[got.status]++;
      if (got.status !== want.status || got.out_key !== want.out_key ||
          got.out_count !== want.out_count || got.last !== want.last) begin
        if (errors < MaxReports) begin
          $display("ERROR: expected status %0d key %h count %0d last %b,",
                   want.status, want.out_key, want.out_count, want.last);
          $display("       got status %0d key %h count %0d last %b",
                   got.status, got.out_key, got.out_count, got.last);
        end
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  count_table_board board = new();
  logic [63:0] pool[KeyPool];
  int pool_live;

  keyed_counter_overflow_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) board.check_response(rsp_o);
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one request, optionally after an idle burst, and wait until busy falls
  task automatic send_request(input req_type_e t, input logic [63:0] k,
                              input logic [63:0] d, input bit gaps);
    req_t r;
    int idle;
    r.req_type = t;
    r.key = k;
    r.delta = d;
    if (gaps && $urandom_range(0, 2) == 0) begin
      idle = $urandom_range(1, 8);
      repeat (idle) begin
        @(negedge clk_i);
        start = 1'b0;
      end
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.take_request(r);
  endtask

  // Mostly reused keys so entries merge and the table fills up
  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, pool_live - 1)];
    return rand64();
  endfunction

  function automatic logic [63:0] pick_delta(logic [63:0] k);
    case ($urandom_range(0, 6))
      0: return rand64();
      1: return 64'sh7fff_ffff_ffff_ffff;
      2: return 64'sh8000_0000_0000_0000;
      3: return -board.count_of(k);   // brings the entry back to zero
      4: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return 64'($urandom_range(1, 1000));
    endcase
  endfunction

  initial begin
    bit gaps;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < KeyPool; i++) pool[i] = rand64();
    pool_live = KeyPool;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty drain, key zero, wrap-around, skipped entries
    send_request(REQ_DRAIN, '1, rand64(), 1'b0);
    send_request(REQ_ACCUM, '0, 64'sh7fff_ffff_ffff_ffff, 1'b0);
    send_request(REQ_ACCUM, '0, 64'sd1, 1'b0);
    send_request(REQ_ACCUM, '1, 64'sh8000_0000_0000_0000, 1'b0);
    send_request(REQ_ACCUM, 64'd5, '0, 1'b0);
    send_request(REQ_DRAIN, rand64(), rand64(), 1'b0);

    // Directed: fill the table, drop on full, merge on full, full drain
    for (int i = 0; i < TableEntries; i++)
      send_request(REQ_ACCUM, 64'h100 + 64'(i), rand64(), 1'b1);
    send_request(REQ_ACCUM, 64'hdead_beef_0000_0001, 64'sd7, 1'b0);
    send_request(REQ_ACCUM, 64'h100, 64'sd3, 1'b0);
    send_request(REQ_DRAIN, rand64(), rand64(), 1'b0);

    // Random traffic; no idling in the tail
    gaps = 1'b1;
    for (int i = 0; i < RandItems; i++) begin
      logic [63:0] k;
      if (i % 32 == 0) begin
        gaps = $urandom_range(0, 1);
        pool_live = $urandom_range(3, KeyPool);
      end
      if (i >= RandItems - FlatTail) gaps = 1'b0;
      if ($urandom_range(0, 19) == 0) begin
        send_request(REQ_DRAIN, rand64(), rand64(), gaps);
      end else begin
        k = pick_key();
        send_request(REQ_ACCUM, k, pick_delta(k), gaps);
      end
    end
    @(negedge clk_i);
    start = 1'b0;

    while (board.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d requests (%0d drains): %0d merged, %0d inserted, %0d dropped,",
             board.requests, board.drains, board.seen[ST_MERGED],
             board.seen[ST_INSERTED], board.seen[ST_DROPPED]);
    $display("%0d entries drained, %0d empty drains, %0d mismatches.",
             board.seen[ST_DRAINED], board.seen[ST_EMPTY], board.errors);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
